### hdl/mep_pkg.sv
package mep_pkg;

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Window coordinates are signed fixed point in a 32-bit word.
   localparam int COORD_W = 32;

   // Width of the iterate z. A point that has not escaped has both parts
   // below 4.0, so the next value stays below 2^31 + 2^(F+4), which fits here
   // for every fraction width up to 28.
   localparam int Z_W = 34;

   // Shared multiplier operand widths. Operand A also carries the 33-bit window
   // span, and operand B the zero-extended pixel index.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;

   // Result gray level.
   localparam int GRAY_W = 8;

   // Escape radius in whole units, and the gray scale top (2^GRAY_W - 1).
   localparam int ESC_RADIUS = 4;
   localparam int GRAY_MAX   = 255;

   // Reset values of the configuration registers.
   localparam logic signed [COORD_W-1:0] MIN_X_RESET = -32'sd33554432;
   localparam logic signed [COORD_W-1:0] MAX_X_RESET = 32'sd16777216;
   localparam logic signed [COORD_W-1:0] MIN_Y_RESET = -32'sd25165824;
   localparam logic signed [COORD_W-1:0] MAX_Y_RESET = 32'sd25165824;
   localparam int MAX_ITER_RESET = 1000;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_X        = 3'd0,
      REG_MAX_X        = 3'd1,
      REG_MIN_Y        = 3'd2,
      REG_MAX_Y        = 3'd3,
      REG_MAX_ITER     = 3'd4,
      REG_IMAGE_WIDTH  = 3'd5,
      REG_IMAGE_HEIGHT = 3'd6
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_MAP_MUL,
      S_MAP_DIV,
      S_MAP_WAIT,
      S_ITER_CHECK,
      S_SQ_I,
      S_CROSS,
      S_UPDATE,
      S_GRAY,
      S_GRAY_WAIT,
      S_DONE
   } state_type;

endpackage

### hdl/mep_chan_if.sv
// Request channel: one pixel position.
interface mep_req_if #(parameter int DIM_BITS = 12);
   logic                valid;
   logic                ready;
   logic [DIM_BITS-1:0] pixel_col;
   logic [DIM_BITS-1:0] pixel_row;

   modport source (output valid, output pixel_col, output pixel_row, input ready);
   modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// Response channel: iteration count and gray level of one pixel.
interface mep_rsp_if #(parameter int ITER_BITS = 16);
   logic                        valid;
   logic                        ready;
   logic [ITER_BITS-1:0]        iter_count;
   logic [mep_pkg::GRAY_W-1:0]  gray_level;

   modport source (output valid, output iter_count, output gray_level, input ready);
   modport sink   (input valid, input iter_count, input gray_level, output ready);
endinterface

// Configuration write channel.
interface mep_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mep_pkg::CSR_IDX_W-1:0]  index;
   logic [mep_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/mep_mul.sv
module mep_mul #(
   parameter int A_W = 33,
   parameter int B_W = 32
) (
   input  logic                      clock,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] product
);

   logic signed [A_W+B_W-1:0] product_ff;
   logic signed [A_W+B_W-1:0] product_in;

   // Full signed product; the result is registered before anyone uses it.
   assign product_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### hdl/mep_div.sv
module mep_div #(
   parameter int DVD_W = 44,
   parameter int DVS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             trial_ge;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign trial     = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});

   // The dividend shifts out of the top of quo_ff while quotient bits enter.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], trial_ge};
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time engine for one pixel at a time.
// A request on req_if carries a pixel column and row. The block maps them into
// the complex window held in the configuration registers, iterates
// z = z*z + c from zero until |z|^2 reaches 16 or the count reaches max_iter,
// and returns the count and the gray level 255*count/max_iter on rsp_if.
// Registers are written through csr_if (always ready); the user must write
// them only while no request is in flight, which the block does not enforce.
// An unknown index is ignored. One signed multiplier and one bit-serial
// divider are shared under a sequencer. Each axis is mapped with one
// product and, for a nonzero image size, one division; each iteration forms
// the two squares and the cross product and then updates z; the gray level
// takes one more division, unless max_iter is zero. The divider length and
// the iteration loop set the time per pixel.
// One request is worked on at a time; req_if.ready is high only while idle.
// The result sits in an output register, so the next request is taken even
// while rsp_if is stalled; a finished pixel waits for that register to empty.
// Synchronous reset returns the sequencer to idle, drops rsp_if.valid and
// loads the default window, 1000 iterations and a 640 x 480 image.
module mandelbrot_escape_pixel #(
   parameter int DIM_BITS        = 12,
   parameter int ITER_BITS       = 16,
   parameter int COORD_FRAC_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   mep_req_if.sink    req_if,
   mep_rsp_if.source  rsp_if,
   mep_csr_if.sink    csr_if
);

   import mep_pkg::*;

   localparam int SIZE_W = DIM_BITS + 1;
   localparam int DVD_W  = COORD_W + DIM_BITS;
   localparam int DVS_W  = (SIZE_W > ITER_BITS) ? SIZE_W : ITER_BITS;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int SUM_W  = DVD_W + 2;

   localparam logic signed [Z_W-1:0]    ESC_LIM     = Z_W'(ESC_RADIUS) <<< COORD_FRAC_BITS;
   localparam logic signed [Z_W-1:0]    ESC_LIM_NEG = -ESC_LIM;
   localparam logic signed [PROD_W-1:0] SQ_LIM      = PROD_W'(ESC_LIM) * PROD_W'(ESC_LIM);
   localparam logic signed [SUM_W-1:0]  C_MAX       = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0]  C_MIN       = ~C_MAX;

   // Configuration registers.
   logic signed [COORD_W-1:0] min_x_ff, min_x_in;
   logic signed [COORD_W-1:0] max_x_ff, max_x_in;
   logic signed [COORD_W-1:0] min_y_ff, min_y_in;
   logic signed [COORD_W-1:0] max_y_ff, max_y_in;
   logic [ITER_BITS-1:0]      max_iter_ff, max_iter_in;
   logic [SIZE_W-1:0]         width_ff, width_in;
   logic [SIZE_W-1:0]         height_ff, height_in;

   // Sequencer and working registers.
   state_type                 state_ff, state_in;
   logic                      axis_ff, axis_in;
   logic [DIM_BITS-1:0]       col_ff, col_in;
   logic [DIM_BITS-1:0]       row_ff, row_in;
   logic                      neg_ff, neg_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [Z_W-1:0]     zr_ff, zr_in;
   logic signed [Z_W-1:0]     zi_ff, zi_in;
   logic signed [PROD_W-1:0]  sq_r_ff, sq_r_in;
   logic signed [PROD_W-1:0]  sq_i_ff, sq_i_in;
   logic [ITER_BITS-1:0]      count_ff, count_in;
   logic [GRAY_W-1:0]         gray_ff, gray_in;

   // Output register.
   logic                      out_valid_ff, out_valid_in;
   logic [ITER_BITS-1:0]      out_count_ff, out_count_in;
   logic [GRAY_W-1:0]         out_gray_ff, out_gray_in;

   // Control decoded from the state.
   logic                      req_ready;
   logic                      req_take;
   logic                      csr_take;
   logic                      out_load;
   logic                      div_start;
   logic                      map_step;

   // Shared unit connections.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [DVD_W-1:0]          div_dividend;
   logic [DVS_W-1:0]          div_divisor;
   logic                      div_busy;
   logic                      div_done;
   logic [DVD_W-1:0]          div_q;

   // Datapath helpers.
   logic signed [MUL_A_W-1:0] span;
   logic [DIM_BITS-1:0]       pix;
   logic [SIZE_W-1:0]         size;
   logic signed [COORD_W-1:0] lo;
   logic                      size_zero;
   logic signed [PROD_W-1:0]  prod_mag;
   logic signed [SUM_W-1:0]   q_signed;
   logic signed [SUM_W-1:0]   c_sum;
   logic signed [COORD_W-1:0] c_sat;
   logic signed [COORD_W-1:0] c_map;
   logic                      bound_esc;
   logic                      iter_stop;
   logic signed [PROD_W-1:0]  sum_sq;
   logic signed [PROD_W-1:0]  diff_sq;
   logic signed [PROD_W-1:0]  sh_r;
   logic signed [PROD_W-1:0]  sh_i;
   logic signed [Z_W-1:0]     zr_next;
   logic signed [Z_W-1:0]     zi_next;
   logic                      sq_esc;
   logic [DVD_W-1:0]          cnt_ext;
   logic [DVD_W-1:0]          gray_dvd;

   // Shared units.
   mep_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (prod)
   );

   mep_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // Handshakes.
   assign req_take = req_if.valid && req_ready;
   assign csr_take = csr_if.valid;

   // Axis selection for the coordinate mapping.
   assign span      = axis_ff ? (MUL_A_W'(max_y_ff) - MUL_A_W'(min_y_ff))
                              : (MUL_A_W'(max_x_ff) - MUL_A_W'(min_x_ff));
   assign pix       = axis_ff ? row_ff : col_ff;
   assign size      = axis_ff ? height_ff : width_ff;
   assign lo        = axis_ff ? min_y_ff : min_x_ff;
   assign size_zero = (size == '0);

   // Mapping: divide the magnitude, restore the sign, add the edge, saturate.
   assign prod_mag = prod[PROD_W-1] ? -prod : prod;
   assign q_signed = neg_ff ? -signed'({2'b00, div_q}) : signed'({2'b00, div_q});
   assign c_sum    = SUM_W'(lo) + q_signed;

   always_comb begin
      priority if (c_sum > C_MAX) begin
         c_sat = C_MAX[COORD_W-1:0];
      end else if (c_sum < C_MIN) begin
         c_sat = C_MIN[COORD_W-1:0];
      end else begin
         c_sat = c_sum[COORD_W-1:0];
      end
   end

   assign c_map    = (state_ff == S_MAP_DIV) ? lo : c_sat;
   assign map_step = ((state_ff == S_MAP_DIV) && size_zero)
                  || ((state_ff == S_MAP_WAIT) && div_done);

   // A part of magnitude 4 or more has escaped without squaring; this also
   // keeps both parts narrow enough for the multiplier.
   assign bound_esc = (zr_ff >= ESC_LIM) || (zr_ff <= ESC_LIM_NEG)
                   || (zi_ff >= ESC_LIM) || (zi_ff <= ESC_LIM_NEG);
   assign iter_stop = (count_ff >= max_iter_ff) || bound_esc;

   // Iteration update from the registered squares and cross product.
   assign sum_sq  = sq_r_ff + sq_i_ff;
   assign sq_esc  = (sum_sq >= SQ_LIM);
   assign diff_sq = sq_r_ff - sq_i_ff;
   assign sh_r    = diff_sq >>> COORD_FRAC_BITS;
   assign sh_i    = prod >>> (COORD_FRAC_BITS - 1);
   assign zr_next = signed'(sh_r[Z_W-1:0]) + Z_W'(cx_ff);
   assign zi_next = signed'(sh_i[Z_W-1:0]) + Z_W'(cy_ff);

   // Gray dividend: count * 255 as (count << 8) - count.
   assign cnt_ext  = DVD_W'(count_ff);
   assign gray_dvd = (cnt_ext << GRAY_W) - cnt_ext;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_MAP_MUL;
            end
         end
         S_MAP_MUL: begin
            state_in = S_MAP_DIV;
         end
         S_MAP_DIV: begin
            if (!size_zero) begin
               state_in = S_MAP_WAIT;
            end else if (axis_ff) begin
               state_in = S_ITER_CHECK;
            end else begin
               state_in = S_MAP_MUL;
            end
         end
         S_MAP_WAIT: begin
            if (div_done) begin
               state_in = axis_ff ? S_ITER_CHECK : S_MAP_MUL;
            end
         end
         S_ITER_CHECK: begin
            state_in = iter_stop ? S_GRAY : S_SQ_I;
         end
         S_SQ_I: begin
            state_in = S_CROSS;
         end
         S_CROSS: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = sq_esc ? S_GRAY : S_ITER_CHECK;
         end
         S_GRAY: begin
            state_in = (max_iter_ff == '0) ? S_DONE : S_GRAY_WAIT;
         end
         S_GRAY_WAIT: begin
            if (div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State-decoded controls and shared unit operands.
   always_comb begin
      req_ready    = 1'b0;
      out_load     = 1'b0;
      div_start    = 1'b0;
      div_dividend = prod_mag[DVD_W-1:0];
      div_divisor  = DVS_W'(size);
      mul_a        = span;
      mul_b        = signed'(MUL_B_W'(pix));
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_MAP_DIV: begin
            div_start = !size_zero;
         end
         S_ITER_CHECK: begin
            mul_a = signed'(zr_ff[MUL_A_W-1:0]);
            mul_b = signed'(zr_ff[MUL_B_W-1:0]);
         end
         S_SQ_I: begin
            mul_a = signed'(zi_ff[MUL_A_W-1:0]);
            mul_b = signed'(zi_ff[MUL_B_W-1:0]);
         end
         S_CROSS: begin
            mul_a = signed'(zr_ff[MUL_A_W-1:0]);
            mul_b = signed'(zi_ff[MUL_B_W-1:0]);
         end
         S_GRAY: begin
            div_start    = (max_iter_ff != '0);
            div_dividend = gray_dvd;
            div_divisor  = DVS_W'(max_iter_ff);
         end
         S_DONE: begin
            out_load = !out_valid_ff || rsp_if.ready;
         end
         default: begin
         end
      endcase
   end

   // Configuration register writes.
   always_comb begin
      min_x_in    = min_x_ff;
      max_x_in    = max_x_ff;
      min_y_in    = min_y_ff;
      max_y_in    = max_y_ff;
      max_iter_in = max_iter_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      if (csr_take) begin
         unique case (csr_index_type'(csr_if.index))
            REG_MIN_X:        min_x_in    = signed'(csr_if.data);
            REG_MAX_X:        max_x_in    = signed'(csr_if.data);
            REG_MIN_Y:        min_y_in    = signed'(csr_if.data);
            REG_MAX_Y:        max_y_in    = signed'(csr_if.data);
            REG_MAX_ITER:     max_iter_in = csr_if.data[ITER_BITS-1:0];
            REG_IMAGE_WIDTH:  width_in    = csr_if.data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_in   = csr_if.data[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Working register updates.
   always_comb begin
      axis_in  = axis_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      neg_in   = neg_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      sq_r_in  = sq_r_ff;
      sq_i_in  = sq_i_ff;
      count_in = count_ff;
      gray_in  = gray_ff;

      // A new request starts from z = 0 on the x axis.
      if (req_take) begin
         col_in   = req_if.pixel_col;
         row_in   = req_if.pixel_row;
         axis_in  = 1'b0;
         zr_in    = '0;
         zi_in    = '0;
         count_in = '0;
      end

      if (state_ff == S_MAP_DIV) begin
         neg_in = prod[PROD_W-1];
      end

      // Store one mapped coordinate and move to the other axis.
      if (map_step) begin
         if (axis_ff) begin
            cy_in = c_map;
         end else begin
            cx_in   = c_map;
            axis_in = 1'b1;
         end
      end

      if (state_ff == S_SQ_I) begin
         sq_r_in = prod;
      end
      if (state_ff == S_CROSS) begin
         sq_i_in = prod;
      end

      if ((state_ff == S_UPDATE) && !sq_esc) begin
         zr_in    = zr_next;
         zi_in    = zi_next;
         count_in = ITER_BITS'(count_ff + 1'b1);
      end

      if (state_ff == S_GRAY) begin
         gray_in = '0;
      end
      if ((state_ff == S_GRAY_WAIT) && div_done) begin
         gray_in = div_q[GRAY_W-1:0];
      end
   end

   // Output register: loaded when a pixel finishes, emptied when taken.
   always_comb begin
      out_count_in = out_count_ff;
      out_gray_in  = out_gray_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_count_in = count_ff;
         out_gray_in  = gray_ff;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         min_x_ff     <= MIN_X_RESET;
         max_x_ff     <= MAX_X_RESET;
         min_y_ff     <= MIN_Y_RESET;
         max_y_ff     <= MAX_Y_RESET;
         max_iter_ff  <= ITER_BITS'(MAX_ITER_RESET);
         width_ff     <= SIZE_W'(WIDTH_RESET);
         height_ff    <= SIZE_W'(HEIGHT_RESET);
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         max_iter_ff  <= max_iter_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
      axis_ff      <= axis_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      neg_ff       <= neg_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      sq_r_ff      <= sq_r_in;
      sq_i_ff      <= sq_i_in;
      count_ff     <= count_in;
      gray_ff      <= gray_in;
      out_count_ff <= out_count_in;
      out_gray_ff  <= out_gray_in;
   end

   // Port drive.
   assign req_if.ready      = req_ready;
   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.iter_count = out_count_ff;
   assign rsp_if.gray_level = out_gray_ff;

`ifndef SYNTHESIS
   // The divider is never restarted while it is still working.
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider started while busy");

   // A divider result only arrives while the sequencer waits for one.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_MAP_WAIT || state_ff == S_GRAY_WAIT))
      else $error("divider result arrived outside a wait state");

   // A delivered count never exceeds the iteration limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.iter_count <= max_iter_ff))
      else $error("iteration count above limit");
`endif

endmodule
